// ===== sv/gtpu_pkg.sv =====
package gtpu_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES_DEFAULT = 16;
    localparam int ENTRY_INDEX_W         = 4;

    // Field widths
    localparam int POS_W  = 7;
    localparam int PORT_W = 16;
    localparam int WORD_W = 32;

    // Reset value of the GTP-U UDP destination port
    localparam logic [PORT_W-1:0] TUNNEL_UDP_PORT_RESET = 16'd2152;

    // Header constants
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;

    // Byte offsets in the frame (outer IPv4 header taken as 20 bytes)
    localparam logic [POS_W-1:0] POS_ETYPE_HI  = 7'd12;
    localparam logic [POS_W-1:0] POS_ETYPE_LO  = 7'd13;
    localparam logic [POS_W-1:0] POS_IP_PROTO  = 7'd23;
    localparam logic [POS_W-1:0] POS_DPORT_HI  = 7'd36;
    localparam logic [POS_W-1:0] POS_DPORT_LO  = 7'd37;
    localparam logic [POS_W-1:0] POS_TEID_FST  = 7'd46;
    localparam logic [POS_W-1:0] POS_TEID_LST  = 7'd49;
    localparam logic [POS_W-1:0] POS_INNER_FST = 7'd62;
    localparam logic [POS_W-1:0] POS_INNER_LST = 7'd65;
    localparam logic [POS_W-1:0] POS_MAX       = 7'd127;

    // Minimum frame lengths for each header check
    localparam logic [POS_W-1:0] L2_MIN_LEN    = 7'd14;
    localparam logic [POS_W-1:0] IP_MIN_LEN    = 7'd34;
    localparam logic [POS_W-1:0] UDP_MIN_LEN   = 7'd42;
    localparam logic [POS_W-1:0] DECAP_MIN_LEN = 7'd50;
    localparam logic [POS_W-1:0] INNER_MIN_LEN = 7'd70;

    // Input operations
    typedef enum logic {
        OP_BYTE  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    // Verdict codes; a decap verdict means the outer 36 bytes are stripped
    typedef enum logic [1:0] {
        VERDICT_PASS  = 2'd0,
        VERDICT_DECAP = 2'd1,
        VERDICT_DROP  = 2'd2,
        VERDICT_ABORT = 2'd3
    } verdict_t;

endpackage

// ===== sv/gtpu_uplink_classifier.sv =====
// GTP-U uplink classifier.
// Frames enter one byte per transfer on the input channel (operation = byte),
// starting at the Ethernet destination address; last_byte marks the end.
// A transfer with operation = write loads one slot of the tunnel table
// (TEID key, expected inner source address, live mark) and gives no result.
// Each frame gives exactly one result (verdict, frame_length) on the output
// channel; all other transfers give none.
// Throughput: one input transfer per cycle, byte or table write, while in_stall is low.
// The snapshot register loads at the edge that takes the last byte; the result
// register, which drives out_valid, loads from it once the output is free.
// The TEID is compared against all table slots in parallel in the snapshot stage.
// A stalled result holds in the output register; the snapshot stage keeps
// running until it is also full, then in_stall is raised.
// cfg_write loads the tunnel UDP port; do so only while no frame is open.
// Reset clears the frame state, all table live marks, both pipeline stages,
// and sets the UDP port to 2152. No clearing pass is needed.
module gtpu_uplink_classifier
    import gtpu_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration
    input  logic                     cfg_write,
    input  logic [PORT_W-1:0]        cfg_data,
    // input channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     operation,
    input  logic [7:0]               packet_byte,
    input  logic                     last_byte,
    input  logic [ENTRY_INDEX_W-1:0] entry_index,
    input  logic                     entry_valid,
    input  logic [WORD_W-1:0]        entry_tunnel_id,
    input  logic [WORD_W-1:0]        entry_ue_address,
    // output channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               verdict,
    output logic [POS_W-1:0]         frame_length
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // Configuration register
    logic [PORT_W-1:0] udp_port_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            udp_port_reg <= TUNNEL_UDP_PORT_RESET;
        else if (cfg_write)
            udp_port_reg <= cfg_data;
    end

    // Handshake and pipeline control
    logic in_accept;
    logic byte_accept;
    logic frame_end;
    logic table_write;
    logic out_load;
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;

    assign out_load    = !out_valid_reg || !out_stall;
    assign in_stall    = s1_valid_reg && !out_load;
    assign in_accept   = in_valid && !in_stall;
    assign byte_accept = in_accept && (op_t'(operation) == OP_BYTE);
    assign table_write = in_accept && (op_t'(operation) == OP_WRITE);
    assign frame_end   = byte_accept && last_byte;

    // Tunnel table: keys and addresses need no reset, live marks do
    logic [WORD_W-1:0]        key_reg  [TABLE_ENTRIES];
    logic [WORD_W-1:0]        addr_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] live_reg;
    logic                     wr_in_range;
    logic [IDX_W-1:0]         wr_idx;

    assign wr_in_range = 32'(entry_index) < TABLE_ENTRIES;
    assign wr_idx      = IDX_W'(entry_index);

    always_ff @(posedge clk)
    begin
        if (table_write && wr_in_range)
        begin
            key_reg[wr_idx]  <= entry_tunnel_id;
            addr_reg[wr_idx] <= entry_ue_address;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            live_reg <= '0;
        else if (table_write && wr_in_range)
            live_reg[wr_idx] <= entry_valid;
    end

    // Per-frame header capture
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [15:0]       etype_reg, etype_next;
    logic [7:0]        proto_reg, proto_next;
    logic [PORT_W-1:0] dport_reg, dport_next;
    logic [WORD_W-1:0] teid_reg, teid_next;
    logic [WORD_W-1:0] inner_reg, inner_next;
    logic [POS_W-1:0]  len_cur;

    assign len_cur = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 7'd1;

    always_comb
    begin
        etype_next = etype_reg;
        proto_next = proto_reg;
        dport_next = dport_reg;
        teid_next  = teid_reg;
        inner_next = inner_reg;
        if (pos_reg == POS_ETYPE_HI || pos_reg == POS_ETYPE_LO)
            etype_next = {etype_reg[7:0], packet_byte};
        else if (pos_reg == POS_IP_PROTO)
            proto_next = packet_byte;
        else if (pos_reg == POS_DPORT_HI || pos_reg == POS_DPORT_LO)
            dport_next = {dport_reg[7:0], packet_byte};
        else if (pos_reg >= POS_TEID_FST && pos_reg <= POS_TEID_LST)
            teid_next = {teid_reg[23:0], packet_byte};
        else if (pos_reg >= POS_INNER_FST && pos_reg <= POS_INNER_LST)
            inner_next = {inner_reg[23:0], packet_byte};
        pos_next = len_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            etype_reg <= '0;
            proto_reg <= '0;
            dport_reg <= '0;
            teid_reg  <= '0;
            inner_reg <= '0;
        end
        else if (frame_end)
        begin
            pos_reg   <= '0;
            etype_reg <= '0;
            proto_reg <= '0;
            dport_reg <= '0;
            teid_reg  <= '0;
            inner_reg <= '0;
        end
        else if (byte_accept)
        begin
            pos_reg   <= pos_next;
            etype_reg <= etype_next;
            proto_reg <= proto_next;
            dport_reg <= dport_next;
            teid_reg  <= teid_next;
            inner_reg <= inner_next;
        end
    end

    // Snapshot stage: header fields of the frame that just ended
    logic [POS_W-1:0]  s1_len_reg;
    logic [15:0]       s1_etype_reg;
    logic [7:0]        s1_proto_reg;
    logic [PORT_W-1:0] s1_dport_reg;
    logic [WORD_W-1:0] s1_teid_reg;
    logic [WORD_W-1:0] s1_inner_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (frame_end)
            s1_valid_next = 1'b1;
        else if (out_load)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (frame_end)
        begin
            s1_len_reg   <= len_cur;
            s1_etype_reg <= etype_next;
            s1_proto_reg <= proto_next;
            s1_dport_reg <= dport_next;
            s1_teid_reg  <= teid_next;
            s1_inner_reg <= inner_next;
        end
    end

    // Parallel TEID lookup, lowest live slot wins
    logic              hit;
    logic [WORD_W-1:0] hit_addr;

    always_comb
    begin
        hit      = 1'b0;
        hit_addr = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (live_reg[i] && key_reg[i] == s1_teid_reg)
            begin
                hit      = 1'b1;
                hit_addr = addr_reg[i];
            end
        end
    end

    // Verdict, checks in priority order
    verdict_t verdict_next;

    always_comb
    begin
        if (s1_len_reg < L2_MIN_LEN)
            verdict_next = VERDICT_PASS;
        else if (s1_etype_reg != ETHERTYPE_IPV4)
            verdict_next = VERDICT_PASS;
        else if (s1_len_reg < IP_MIN_LEN)
            verdict_next = VERDICT_ABORT;
        else if (s1_proto_reg != IP_PROTO_UDP)
            verdict_next = VERDICT_PASS;
        else if (s1_len_reg < UDP_MIN_LEN)
            verdict_next = VERDICT_ABORT;
        else if (s1_dport_reg != udp_port_reg)
            verdict_next = VERDICT_PASS;
        else if (s1_len_reg < INNER_MIN_LEN)
            verdict_next = VERDICT_ABORT;
        else if (!hit)
            verdict_next = VERDICT_DROP;
        else if (hit_addr != s1_inner_reg)
            verdict_next = VERDICT_DROP;
        else if (s1_len_reg < DECAP_MIN_LEN)
            verdict_next = VERDICT_ABORT;
        else
            verdict_next = VERDICT_DECAP;
    end

    // Result register
    verdict_t         verdict_reg;
    logic [POS_W-1:0] len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            verdict_reg <= verdict_next;
            len_reg     <= s1_len_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign verdict      = verdict_reg;
    assign frame_length = len_reg;

    // Checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free pipeline stage");

    a_frame_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> (pos_reg == '0 && teid_reg == '0 && inner_reg == '0))
        else $error("frame state not cleared after last byte");

    a_decap_long_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && verdict_reg == VERDICT_DECAP) |-> len_reg >= INNER_MIN_LEN)
        else $error("decap verdict on a short frame");

    a_abort_short_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && verdict_reg == VERDICT_ABORT) |-> len_reg < INNER_MIN_LEN)
        else $error("abort verdict on a full-length frame");

    a_end_reaches_s1: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> s1_valid_reg)
        else $error("ended frame lost before snapshot stage");

endmodule

// ===== tb/gtpu_uplink_classifier_tb.sv =====
module gtpu_uplink_classifier_tb;
    import gtpu_pkg::*;

    localparam int SLOTS        = TABLE_ENTRIES_DEFAULT;
    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 60;
    localparam int PHASE_FRAMES = 1;

    // Fixed tunnel used by the directed tests
    localparam logic [WORD_W-1:0] DIR_TEID    = 32'h1234_5678;
    localparam logic [WORD_W-1:0] DIR_UE      = 32'h0A00_0002;
    localparam logic [WORD_W-1:0] SHARED_TEID = 32'h00C0_FFEE;

    typedef enum {STALL_OFF, STALL_LIGHT, STALL_HEAVY} stall_mode_t;
    typedef enum {KIND_TUNNEL, KIND_UNKNOWN_TEID, KIND_BROKEN, KIND_NOISE} frame_kind_t;

    typedef struct {
        verdict_t           verdict;
        logic [POS_W-1:0]   length;
    } frame_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [PORT_W-1:0]        cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     operation = OP_BYTE;
    logic [7:0]               packet_byte = '0;
    logic                     last_byte = 1'b0;
    logic [ENTRY_INDEX_W-1:0] entry_index = '0;
    logic                     entry_valid = 1'b0;
    logic [WORD_W-1:0]        entry_tunnel_id = '0;
    logic [WORD_W-1:0]        entry_ue_address = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [1:0]               verdict;
    logic [POS_W-1:0]         frame_length;

    // Classifier state kept by the testbench
    logic [PORT_W-1:0] tunnel_port = TUNNEL_UDP_PORT_RESET;
    int unsigned       cur_pos = 0;
    logic [15:0]       cur_etype = '0;
    logic [7:0]        cur_proto = '0;
    logic [15:0]       cur_dport = '0;
    logic [31:0]       cur_teid = '0;
    logic [31:0]       cur_inner = '0;
    logic [31:0]       slot_key [SLOTS];
    logic [31:0]       slot_addr [SLOTS];
    logic              slot_live [SLOTS];

    frame_result_t expected_verdicts [$];
    int            mismatch_count = 0;
    int            byte_items = 0;
    int            frame_count = 0;

    // Sender and receiver pacing
    int          burst_left = 0;
    bit          sender_gaps = 1'b0;
    stall_mode_t stall_mode = STALL_OFF;
    int          hold_left = 0;
    int          stall_run = 0;
    int          idle_cycles = 0;

    gtpu_uplink_classifier dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .packet_byte      (packet_byte),
        .last_byte        (last_byte),
        .entry_index      (entry_index),
        .entry_valid      (entry_valid),
        .entry_tunnel_id  (entry_tunnel_id),
        .entry_ue_address (entry_ue_address),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .verdict          (verdict),
        .frame_length     (frame_length)
    );

    always #2 clk = ~clk;

    // Verdict of a finished frame from the captured header fields
    function automatic verdict_t classify_frame(input int unsigned len);
        if (len < L2_MIN_LEN) return VERDICT_PASS;
        if (cur_etype != ETHERTYPE_IPV4) return VERDICT_PASS;
        if (len < IP_MIN_LEN) return VERDICT_ABORT;
        if (cur_proto != IP_PROTO_UDP) return VERDICT_PASS;
        if (len < UDP_MIN_LEN) return VERDICT_ABORT;
        if (cur_dport != tunnel_port) return VERDICT_PASS;
        if (len < INNER_MIN_LEN) return VERDICT_ABORT;
        // lowest live slot with a matching key decides
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_live[i] && slot_key[i] == cur_teid)
            begin
                if (slot_addr[i] != cur_inner) return VERDICT_DROP;
                if (len < DECAP_MIN_LEN) return VERDICT_ABORT;
                return VERDICT_DECAP;
            end
        end
        return VERDICT_DROP;
    endfunction

    // Update the state for one accepted transfer; queue the verdict on a last byte
    function automatic void predict_transfer(input op_t op, input logic [7:0] data,
            input logic last, input logic [ENTRY_INDEX_W-1:0] slot, input logic live,
            input logic [WORD_W-1:0] key, input logic [WORD_W-1:0] addr);
        int unsigned   pos;
        int unsigned   len;
        frame_result_t res;
        if (op == OP_WRITE)
        begin
            if (slot < SLOTS)
            begin
                slot_live[slot] = live;
                slot_key[slot]  = key;
                slot_addr[slot] = addr;
            end
            return;
        end
        pos = cur_pos;
        if (pos == POS_ETYPE_HI || pos == POS_ETYPE_LO)
            cur_etype = {cur_etype[7:0], data};
        else if (pos == POS_IP_PROTO)
            cur_proto = data;
        else if (pos == POS_DPORT_HI || pos == POS_DPORT_LO)
            cur_dport = {cur_dport[7:0], data};
        else if (pos >= POS_TEID_FST && pos <= POS_TEID_LST)
            cur_teid = {cur_teid[23:0], data};
        else if (pos >= POS_INNER_FST && pos <= POS_INNER_LST)
            cur_inner = {cur_inner[23:0], data};
        len = (pos >= POS_MAX) ? POS_MAX : pos + 1;
        if (!last)
        begin
            cur_pos = len;
            return;
        end
        res.verdict = classify_frame(len);
        res.length  = POS_W'(len);
        expected_verdicts.push_back(res);
        cur_pos   = 0;
        cur_etype = '0;
        cur_proto = '0;
        cur_dport = '0;
        cur_teid  = '0;
        cur_inner = '0;
    endfunction

    // One input transfer, with bursts and gaps on the sending side
    task automatic send_item(input op_t op, input logic [7:0] data, input logic last,
            input logic [ENTRY_INDEX_W-1:0] slot, input logic live,
            input logic [WORD_W-1:0] key, input logic [WORD_W-1:0] addr);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = sender_gaps ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid         <= 1'b1;
        operation        <= op;
        packet_byte      <= data;
        last_byte        <= last;
        entry_index      <= slot;
        entry_valid      <= live;
        entry_tunnel_id  <= key;
        entry_ue_address <= addr;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_transfer(op, data, last, slot, live, key, addr);
    endtask

    task automatic send_table_write(input logic [ENTRY_INDEX_W-1:0] slot, input logic live,
            input logic [WORD_W-1:0] key, input logic [WORD_W-1:0] addr);
        send_item(OP_WRITE, 8'($urandom), 1'($urandom), slot, live, key, addr);
    endtask

    // Random slot write; some keys repeat ones already in the table
    task automatic random_table_write();
        logic [WORD_W-1:0] key;
        key = ($urandom_range(0, 3) == 0) ? slot_key[$urandom_range(0, SLOTS - 1)]
                                          : WORD_W'($urandom);
        send_table_write(ENTRY_INDEX_W'($urandom), $urandom_range(0, 4) != 0, key,
                         WORD_W'($urandom));
    endtask

    // Frame with the given header fields over random filler; table writes may land mid-frame
    task automatic send_frame(input int len, input logic [15:0] etype, input logic [7:0] proto,
            input logic [15:0] dport, input logic [31:0] teid, input logic [31:0] inner,
            input int write_pct);
        logic [7:0] octet;
        for (int i = 0; i < len; i++)
        begin
            octet = 8'($urandom);
            if (i == POS_ETYPE_HI) octet = etype[15:8];
            else if (i == POS_ETYPE_LO) octet = etype[7:0];
            else if (i == POS_IP_PROTO) octet = proto;
            else if (i == POS_DPORT_HI) octet = dport[15:8];
            else if (i == POS_DPORT_LO) octet = dport[7:0];
            else if (i >= POS_TEID_FST && i <= POS_TEID_LST)
                octet = teid[8 * (int'(POS_TEID_LST) - i) +: 8];
            else if (i >= POS_INNER_FST && i <= POS_INNER_LST)
                octet = inner[8 * (int'(POS_INNER_LST) - i) +: 8];
            if ($urandom_range(0, 99) < write_pct)
                random_table_write();
            send_item(OP_BYTE, octet, i == len - 1, ENTRY_INDEX_W'($urandom), 1'($urandom),
                      WORD_W'($urandom), WORD_W'($urandom));
            byte_items++;
        end
        frame_count++;
    endtask

    // Stop offering and wait until every verdict is back and the pipe is empty
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_tunnel_port(input logic [PORT_W-1:0] value);
        wait_results_drained();
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        tunnel_port = value;
    endtask

    // Each header check at its length boundary, reset port value
    task automatic test_header_checks();
        send_table_write(4'd2, 1'b1, DIR_TEID, DIR_UE);
        send_frame(1, ETHERTYPE_IPV4, IP_PROTO_UDP, tunnel_port, DIR_TEID, DIR_UE, 0);
        send_frame(13, ETHERTYPE_IPV4, IP_PROTO_UDP, tunnel_port, DIR_TEID, DIR_UE, 0);
        send_frame(14, 16'h86DD, IP_PROTO_UDP, tunnel_port, DIR_TEID, DIR_UE, 0);
        send_frame(14, ETHERTYPE_IPV4, IP_PROTO_UDP, tunnel_port, DIR_TEID, DIR_UE, 0);
        send_frame(33, ETHERTYPE_IPV4, IP_PROTO_UDP, tunnel_port, DIR_TEID, DIR_UE, 0);
        send_frame(34, ETHERTYPE_IPV4, 8'd6, tunnel_port, DIR_TEID, DIR_UE, 0);
        send_frame(41, ETHERTYPE_IPV4, IP_PROTO_UDP, tunnel_port, DIR_TEID, DIR_UE, 0);
        send_frame(42, ETHERTYPE_IPV4, IP_PROTO_UDP, tunnel_port ^ 16'h1, DIR_TEID, DIR_UE, 0);
        send_frame(69, ETHERTYPE_IPV4, IP_PROTO_UDP, tunnel_port, DIR_TEID, DIR_UE, 0);
        send_frame(70, ETHERTYPE_IPV4, IP_PROTO_UDP, tunnel_port, ~DIR_TEID, DIR_UE, 0);
    endtask

    // Slot priority, removal, extreme keys, long frames, writes inside a frame
    task automatic test_table_rules();
        send_table_write(4'd5, 1'b1, SHARED_TEID, 32'hC0A8_0005);
        send_table_write(4'd9, 1'b1, SHARED_TEID, 32'hC0A8_0009);
        send_frame(70, ETHERTYPE_IPV4, IP_PROTO_UDP, tunnel_port, SHARED_TEID, 32'hC0A8_0009, 0);
        // removed slot keeps its key but no longer matches
        send_table_write(4'd5, 1'b0, SHARED_TEID, 32'hC0A8_0005);
        send_frame(70, ETHERTYPE_IPV4, IP_PROTO_UDP, tunnel_port, SHARED_TEID, 32'hC0A8_0009, 0);
        send_table_write(4'd0, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
        send_table_write(4'd15, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
        send_frame(70, ETHERTYPE_IPV4, IP_PROTO_UDP, tunnel_port, 32'h0, 32'hFFFF_FFFF, 0);
        // length saturates at 127
        send_frame(130, ETHERTYPE_IPV4, IP_PROTO_UDP, tunnel_port, 32'hFFFF_FFFF, 32'h0, 10);
    endtask

    // Port register at both extremes, then back to the reset value
    task automatic test_port_register();
        set_tunnel_port(16'h0000);
        send_frame(42, ETHERTYPE_IPV4, IP_PROTO_UDP, 16'h0000, DIR_TEID, DIR_UE, 0);
        set_tunnel_port(16'hFFFF);
        send_frame(42, ETHERTYPE_IPV4, IP_PROTO_UDP, 16'hFFFF, DIR_TEID, DIR_UE, 0);
        send_frame(42, ETHERTYPE_IPV4, IP_PROTO_UDP, 16'hFFFE, DIR_TEID, DIR_UE, 0);
        set_tunnel_port(TUNNEL_UDP_PORT_RESET);
    endtask

    // Receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        stall_mode  = STALL_OFF;
        sender_gaps = 1'b0;
        hold_left   = HOLD_CYCLES;
        repeat (30)
            send_frame($urandom_range(1, 3), ETHERTYPE_IPV4, IP_PROTO_UDP, tunnel_port,
                       DIR_TEID, DIR_UE, 0);
        wait_results_drained();
    endtask

    // Mostly tunnel traffic to live slots, plus unknown TEIDs, broken frames and noise
    task automatic test_random_traffic(input logic [PORT_W-1:0] port,
            input stall_mode_t rx_mode, input bit gaps);
        int          items_goal;
        int          frames_goal;
        int          pick;
        int          len;
        int          live_slots [$];
        frame_kind_t kind;
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [15:0] dport;
        logic [31:0] teid;
        logic [31:0] inner;
        logic [31:0] key;
        set_tunnel_port(port);
        stall_mode  = rx_mode;
        sender_gaps = gaps;
        // refill the table; some slots share a key with a lower one
        for (int s = 0; s < SLOTS; s++)
        begin
            key = (s > 0 && $urandom_range(0, 3) == 0) ? slot_key[$urandom_range(0, s - 1)]
                                                       : WORD_W'($urandom);
            send_table_write(ENTRY_INDEX_W'(s), $urandom_range(0, 5) != 0, key,
                             WORD_W'($urandom));
        end
        items_goal  = byte_items + PHASE_ITEMS;
        frames_goal = frame_count + PHASE_FRAMES;
        while (byte_items < items_goal || frame_count < frames_goal)
        begin
            pick = $urandom_range(0, 99);
            kind = (pick < 55) ? KIND_TUNNEL : (pick < 70) ? KIND_UNKNOWN_TEID :
                   (pick < 85) ? KIND_BROKEN : KIND_NOISE;
            len   = ($urandom_range(0, 15) == 0) ? $urandom_range(120, 160)
                                                 : $urandom_range(70, 84);
            etype = ETHERTYPE_IPV4;
            proto = IP_PROTO_UDP;
            dport = tunnel_port;
            teid  = $urandom;
            inner = $urandom;
            live_slots.delete();
            for (int s = 0; s < SLOTS; s++)
                if (slot_live[s]) live_slots.push_back(s);
            if (kind != KIND_UNKNOWN_TEID && kind != KIND_NOISE && live_slots.size() != 0)
            begin
                pick  = live_slots[$urandom_range(0, live_slots.size() - 1)];
                teid  = slot_key[pick];
                inner = ($urandom_range(0, 4) != 0) ? slot_addr[pick] : WORD_W'($urandom);
            end
            if (kind == KIND_BROKEN)
            begin
                case ($urandom_range(0, 3))
                    0: etype = 16'($urandom);
                    1: proto = 8'($urandom);
                    2: dport = 16'($urandom);
                    default: len = $urandom_range(1, 69);
                endcase
            end
            else if (kind == KIND_NOISE)
            begin
                len   = $urandom_range(1, 80);
                etype = $urandom_range(0, 1) ? ETHERTYPE_IPV4 : 16'($urandom);
                proto = 8'($urandom);
                dport = 16'($urandom);
            end
            send_frame(len, etype, proto, dport, teid, inner, 2);
        end
        wait_results_drained();
    endtask

    // Receiver stall pattern
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_run > 0)
            stall_run--;
        else
        begin
            case (stall_mode)
                STALL_LIGHT:
                begin
                    out_stall <= ($urandom_range(0, 3) == 0);
                    stall_run = $urandom_range(0, 3);
                end
                STALL_HEAVY:
                begin
                    out_stall <= ($urandom_range(0, 1) == 0);
                    stall_run = $urandom_range(0, 12);
                end
                default: out_stall <= 1'b0;
            endcase
        end
    end

    // Compare each result transfer with the oldest expected verdict
    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("unexpected result: verdict %0d frame_length %0d", verdict, frame_length);
                mismatch_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (verdict !== want.verdict)
                begin
                    $error("verdict: expected %0d, got %0d", want.verdict, verdict);
                    mismatch_count++;
                end
                if (frame_length !== want.length)
                begin
                    $error("frame_length: expected %0d, got %0d", want.length, frame_length);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            slot_key[s]  = '0;
            slot_addr[s] = '0;
            slot_live[s] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the header, table and port tests run with sender gaps and a light receiver stall
        stall_mode  = STALL_LIGHT;
        sender_gaps = 1'b1;
        test_header_checks();
        test_table_rules();
        test_port_register();
        test_backpressure();
        test_random_traffic(16'($urandom), STALL_HEAVY, 1'b1);

        wait_results_drained();
        if (mismatch_count == 0 && expected_verdicts.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
